// File: hw/rtl/bpte_pkg.sv
package bpte_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int MAX_RUN = 64;

   localparam int LVL_W = $clog2(STACK_DEPTH);
   localparam int RUN_W = $clog2(MAX_RUN);

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic MODE_LITERAL = 1'b1;

   localparam logic [7:0] ESCAPE_CODE = 8'hFF;
   localparam logic [7:0] THR_INDEX = 8'hFF;

   localparam logic [2:0] STAT_OK = 3'd0;
   localparam logic [2:0] STAT_ESC_IN_EXP = 3'd1;
   localparam logic [2:0] STAT_TOO_DEEP = 3'd2;
   localparam logic [2:0] STAT_TRUNC = 3'd3;
   localparam logic [2:0] STAT_ESC_CUT = 3'd4;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic [2:0] status;
   } result_type;

endpackage

// File: hw/rtl/byte_pair_token_expander_core.sv
// byte pair token expander
// req channel: one beat per command. tuser[0] selects load (0) or decode (1).
// a load writes one pair-table entry (index, first, second) and gives no result.
// a decode beat expands one code byte; tlast marks the last code of a message.
// rsp channel: one beat per output byte or status; tlast ends the run of one
// code byte, tuser holds byte_valid and the status code.
// csr_we/csr_wdata set the scheme mode (0 pair, 1 literal); the user must write it
// only while idle; the block itself does not enforce it.
// each table lookup is a memory read (ST_LOOK) then an evaluate (ST_EVAL); a
// pair-mode leaf then gives two bytes, hi then lo, a literal leaf one byte.
// interior nodes give no output. the single read port of the table and the
// stack walk limit the rate.
// reset clears the sequencer, escape state, and mode; table contents persist
// and are undefined until loaded.
// when rsp_tready is low the finished beat waits in the output register and the
// expander holds; a new command is accepted once the previous code is done.
module byte_pair_token_expander_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // code_byte, pair_first, pair_second
   input  logic        req_tlast,   // message_end
   input  logic [0:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // run_last
   output logic [3:0]  rsp_tuser,   // byte_valid, status
   input  logic        csr_we,
   input  logic [0:0]  csr_wdata
);

   logic                 mode_ff;
   logic                 mode_in;
   logic                 out_free;
   logic                 emit;
   bpte_pkg::result_type res;
   logic                 ram_wr_en;
   logic [7:0]           ram_wr_addr;
   logic [15:0]          ram_wr_data;
   logic                 ram_rd_en;
   logic [7:0]           ram_rd_addr;
   logic [15:0]          ram_rd_data;

   assign mode_in = csr_we ? csr_wdata[0] : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   bpte_pair_ram u_pair_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bpte_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_func    (req_tuser[0]),
      .req_code    (req_tdata[7:0]),
      .req_first   (req_tdata[15:8]),
      .req_second  (req_tdata[23:16]),
      .req_end     (req_tlast),
      .mode        (mode_ff),
      .out_free    (out_free),
      .emit        (emit),
      .res         (res),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   bpte_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (emit),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: hw/rtl/bpte_pair_ram.sv
module bpte_pair_ram (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [7:0]  wr_addr,
   input  logic [15:0] wr_data,
   input  logic        rd_en,
   input  logic [7:0]  rd_addr,
   output logic [15:0] rd_data
);

   logic [15:0] mem [256];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bpte_out_reg.sv
module bpte_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  bpte_pkg::result_type res,
   output logic                 out_free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast,
   output logic [3:0]           rsp_tuser
);

   logic                 valid_ff;
   logic                 valid_in;
   bpte_pkg::result_type data_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff.out_byte;
   assign rsp_tlast  = data_ff.run_last;
   assign rsp_tuser  = {data_ff.status, data_ff.byte_valid};

endmodule

// File: hw/rtl/bpte_seq.sv
module bpte_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic [7:0]           req_code,
   input  logic [7:0]           req_first,
   input  logic [7:0]           req_second,
   input  logic                 req_end,
   input  logic                 mode,
   input  logic                 out_free,
   output logic                 emit,
   output bpte_pkg::result_type res,
   output logic                 ram_wr_en,
   output logic [7:0]           ram_wr_addr,
   output logic [15:0]          ram_wr_data,
   output logic                 ram_rd_en,
   output logic [7:0]           ram_rd_addr,
   input  logic [15:0]          ram_rd_data
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_LOOK    = 3'd1;
   localparam logic [2:0] ST_EVAL    = 3'd2;
   localparam logic [2:0] ST_EVAL_LO = 3'd3;
   localparam logic [2:0] ST_ESC_A   = 3'd4;
   localparam logic [2:0] ST_ESC_B   = 3'd5;
   localparam logic [2:0] ST_STAT    = 3'd6;

   logic [2:0]                 state_ff, state_in;
   logic [7:0]                 cur_ff, cur_in;
   logic [bpte_pkg::LVL_W-1:0] level_ff, level_in;
   logic [bpte_pkg::RUN_W-1:0] run_ff, run_in;
   logic [1:0]                 esc_ff, esc_in;
   logic [7:0]                 held_ff, held_in;
   logic [2:0]                 stat_ff, stat_in;
   logic [7:0]                 thr_ff, thr_in;
   logic [7:0]                 stack_ff [bpte_pkg::STACK_DEPTH];

   logic                       stk_push;
   logic [7:0]                 hi, lo, pop_code, tail_byte;
   logic [bpte_pkg::LVL_W-1:0] level_m1;
   logic                       more, literal, run_full, too_deep;

   assign hi        = ram_rd_data[15:8];
   assign lo        = ram_rd_data[7:0];
   assign level_m1  = level_ff - bpte_pkg::LVL_W'(1);
   assign pop_code  = stack_ff[level_m1];
   assign more      = (level_ff != '0);
   assign literal   = (mode == bpte_pkg::MODE_LITERAL);
   assign run_full  = (run_ff >= bpte_pkg::RUN_W'(bpte_pkg::MAX_RUN - 1));
   assign too_deep  = ((bpte_pkg::LVL_W + 1)'(level_ff) + (bpte_pkg::LVL_W + 1)'(2))
                      > (bpte_pkg::LVL_W + 1)'(bpte_pkg::STACK_DEPTH);
   assign tail_byte = (state_ff == ST_EVAL_LO) ? lo : cur_ff;

   assign ram_wr_addr = req_code;
   assign ram_wr_data = {req_first, req_second};

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      level_in    = level_ff;
      run_in      = run_ff;
      esc_in      = esc_ff;
      held_in     = held_ff;
      stat_in     = stat_ff;
      thr_in      = thr_ff;
      req_ready   = (state_ff == ST_IDLE);
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = cur_ff;
      stk_push    = 1'b0;
      emit        = 1'b0;
      res         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_func == bpte_pkg::FUNC_LOAD) begin
                  ram_wr_en = 1'b1;
                  if (req_code == bpte_pkg::THR_INDEX) begin
                     thr_in = req_first;
                  end
               end else if (esc_ff >= 2'd2) begin
                  held_in = req_code;
                  esc_in  = 2'd1;
                  if (req_end) begin
                     esc_in   = 2'd0;
                     stat_in  = bpte_pkg::STAT_ESC_CUT;
                     state_in = ST_STAT;
                  end
               end else if (esc_ff == 2'd1) begin
                  esc_in   = 2'd0;
                  cur_in   = req_code;
                  state_in = ST_ESC_A;
               end else if (!literal && req_code == bpte_pkg::ESCAPE_CODE) begin
                  esc_in = 2'd2;
                  if (req_end) begin
                     esc_in   = 2'd0;
                     stat_in  = bpte_pkg::STAT_ESC_CUT;
                     state_in = ST_STAT;
                  end
               end else begin
                  cur_in      = req_code;
                  level_in    = '0;
                  run_in      = '0;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = req_code;
                  state_in    = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            state_in = ST_EVAL;
         end
         ST_EVAL, ST_EVAL_LO: begin
            if (out_free) begin
               if (state_ff == ST_EVAL && !literal && cur_ff < thr_ff) begin
                  emit = 1'b1;
                  if (run_full) begin
                     res.status   = bpte_pkg::STAT_TRUNC;
                     res.run_last = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     res.out_byte   = hi;
                     res.byte_valid = 1'b1;
                     run_in         = run_ff + bpte_pkg::RUN_W'(1);
                     state_in       = ST_EVAL_LO;
                  end
               end else if (state_ff == ST_EVAL_LO || (literal && hi == cur_ff)) begin
                  emit = 1'b1;
                  if (run_full && more) begin
                     res.status   = bpte_pkg::STAT_TRUNC;
                     res.run_last = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     res.out_byte   = tail_byte;
                     res.byte_valid = 1'b1;
                     res.run_last   = !more;
                     run_in         = run_ff + bpte_pkg::RUN_W'(1);
                     if (more) begin
                        cur_in      = pop_code;
                        level_in    = level_m1;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pop_code;
                        state_in    = ST_LOOK;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
               end else if (!literal && cur_ff == bpte_pkg::ESCAPE_CODE) begin
                  emit         = 1'b1;
                  res.status   = bpte_pkg::STAT_ESC_IN_EXP;
                  res.run_last = 1'b1;
                  state_in     = ST_IDLE;
               end else if (too_deep) begin
                  emit         = 1'b1;
                  res.status   = bpte_pkg::STAT_TOO_DEEP;
                  res.run_last = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  // push second child, descend into first
                  stk_push    = 1'b1;
                  level_in    = level_ff + bpte_pkg::LVL_W'(1);
                  cur_in      = hi;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = hi;
                  state_in    = ST_LOOK;
               end
            end
         end
         ST_ESC_A: begin
            if (out_free) begin
               emit           = 1'b1;
               res.out_byte   = held_ff;
               res.byte_valid = 1'b1;
               state_in       = ST_ESC_B;
            end
         end
         ST_ESC_B: begin
            if (out_free) begin
               emit           = 1'b1;
               res.out_byte   = cur_ff;
               res.byte_valid = 1'b1;
               res.run_last   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_STAT: begin
            if (out_free) begin
               emit         = 1'b1;
               res.status   = stat_ff;
               res.run_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         level_ff <= '0;
         run_ff   <= '0;
         esc_ff   <= 2'd0;
         held_ff  <= 8'd0;
         thr_ff   <= 8'd0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         run_ff   <= run_in;
         esc_ff   <= esc_in;
         held_ff  <= held_in;
         thr_ff   <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      stat_ff <= stat_in;
      if (stk_push) begin
         stack_ff[level_ff] <= lo;
      end
   end

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result issued while output register occupied");

   a_status_ends_run: assert property (@(posedge clock) disable iff (reset)
      (emit && !res.byte_valid) |-> res.run_last)
      else $error("status-only beat not marked last");

   a_eval_after_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |->
         ($past(state_ff) == ST_LOOK || $past(state_ff) == ST_EVAL))
      else $error("table data evaluated without a lookup");

endmodule
